@@ design/assert_macros.svh @@
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER_CLK(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER_CLK(lbl, clk, rstn, cond)
`endif

`endif

@@ design/snz_pkg.sv @@
`default_nettype none
package snz_pkg;

  localparam int unsigned DEF_COORD_FRAC_BITS = 16;
  localparam int unsigned DEF_OUT_FRAC_BITS   = 16;

  localparam int unsigned NUM_CORNERS   = 4;
  localparam int unsigned FRONT_STAGES  = 4;
  localparam int unsigned BACK_LATENCY  = 7;
  localparam int unsigned QUEUE_DEPTH   = 8;
  localparam int unsigned QPW           = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [63:0] PRX  = 64'h5205402B9270C86F;
  localparam logic [63:0] PRY  = 64'h598CD327003817B5;
  localparam logic [63:0] HMUL = 64'h53A3F72DEEC546F5;

  localparam logic signed [21:0] GA = 22'sd457500;
  localparam logic signed [21:0] GB = 22'sd1104503;
  localparam logic signed [21:0] GC = 22'sd156045;
  localparam logic signed [21:0] GD = 22'sd1185278;
  localparam logic signed [21:0] GE = 22'sd727777;
  localparam logic signed [21:0] GF = 22'sd948458;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } corner_t;

  typedef struct packed {
    corner_t [NUM_CORNERS-1:0] crn;
  } item_t;

  typedef struct packed {
    logic           empty;
    logic           full;
    logic [QCW-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic signed [21:0] gx;
    logic signed [21:0] gy;
  } grad_t;

  // reduce a 7-bit value modulo 24 by compare and subtract
  function automatic logic [4:0] mod24(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    if (r >= 7'd96) r = r - 7'd96;
    if (r >= 7'd48) r = r - 7'd48;
    if (r >= 7'd24) r = r - 7'd24;
    return r[4:0];
  endfunction

  function automatic grad_t grad_lookup(input logic [4:0] gi);
    grad_t g;
    unique case (gi)
      5'd0:    g = '{GA, GB};
      5'd1:    g = '{GB, GA};
      5'd2:    g = '{GB, -GA};
      5'd3:    g = '{GA, -GB};
      5'd4:    g = '{-GA, -GB};
      5'd5:    g = '{-GB, -GA};
      5'd6:    g = '{-GB, GA};
      5'd7:    g = '{-GA, GB};
      5'd8:    g = '{GC, GD};
      5'd9:    g = '{GE, GF};
      5'd10:   g = '{GF, GE};
      5'd11:   g = '{GD, GC};
      5'd12:   g = '{GD, -GC};
      5'd13:   g = '{GF, -GE};
      5'd14:   g = '{GE, -GF};
      5'd15:   g = '{GC, -GD};
      5'd16:   g = '{-GC, -GD};
      5'd17:   g = '{-GE, -GF};
      5'd18:   g = '{-GF, -GE};
      5'd19:   g = '{-GD, -GC};
      5'd20:   g = '{-GD, GC};
      5'd21:   g = '{-GF, GE};
      5'd22:   g = '{-GE, GF};
      5'd23:   g = '{-GC, GD};
      default: g = '{22'sd0, 22'sd0};
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

@@ design/snz_front.sv @@
`default_nettype none
module snz_front #(
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  output logic                    push_o,
  output snz_pkg::item_t          item_o,
  output logic [2:0]              inflight_o
);
  import snz_pkg::*;

  localparam int unsigned QW  = 66 - COORD_FRAC_BITS;
  localparam int unsigned BW  = QW - 32;
  localparam int unsigned SHL = 32 - COORD_FRAC_BITS;
  localparam int unsigned SKR = COORD_FRAC_BITS - 2;

  localparam logic [28:0]        SKEW_Q30   = 29'd393016785;
  localparam logic signed [31:0] UNSKEW_Q32 = -32'sd907633386;

  localparam logic signed [35:0] OFS_UNS  = -36'sd907633386;
  localparam logic signed [35:0] OFS_OPP  = 36'sd2479700524;
  localparam logic signed [35:0] OFS_ONE  = 36'sd3387333910;
  localparam logic signed [35:0] OFS_DHI  = 36'sd5867034434;
  localparam logic signed [35:0] OFS_DLO  = 36'sd1572067138;
  localparam logic signed [34:0] ONE_Q32  = 35'sd4294967296;

  logic [FRONT_STAGES-1:0] vld_q, vld_d;

  // stage 1: skew product
  logic signed [32:0] psum;
  logic signed [62:0] s1_prod_d, s1_prod_q;
  logic signed [31:0] s1_px_q, s1_py_q;

  // stage 2: skewed position split into cell and fraction
  logic signed [62:0] sk;
  logic signed [QW-1:0] qx, qy;
  logic signed [BW-1:0] s2_bx_q, s2_by_q;
  logic [31:0]          s2_sx_q, s2_sy_q;

  // stage 3: hash partial products and unskew offset
  logic signed [63:0] s3_hxl_d, s3_hyl_d, s3_hxl_q, s3_hyl_q;
  logic [31:0]        s3_hxh_d, s3_hyh_d, s3_hxh_q, s3_hyh_q;
  logic [32:0]        ssum;
  logic signed [65:0] tprod;
  logic signed [32:0] s3_t_q;
  logic [31:0]        s3_sx_q, s3_sy_q;

  // stage 4: base hashes, offsets, region flags
  logic [63:0]        s4_hx_q, s4_hy_q;
  logic signed [35:0] s4_ux_d, s4_uy_d, s4_ux_q, s4_uy_q;
  logic signed [34:0] xa, ya;
  logic s4_lower_q, s4_xgt_q, s4_ygt_q, s4_xneg_q, s4_yneg_q;

  assign vld_d = {vld_q[FRONT_STAGES-2:0], accept_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign psum      = 33'(pos_x_i) + 33'(pos_y_i);
  assign s1_prod_d = psum * $signed({1'b0, SKEW_Q30});

  always_ff @(posedge clk_i) begin
    s1_prod_q <= s1_prod_d;
    s1_px_q   <= pos_x_i;
    s1_py_q   <= pos_y_i;
  end

  assign sk = s1_prod_q >>> SKR;
  assign qx = (QW'(s1_px_q) <<< SHL) + QW'(sk);
  assign qy = (QW'(s1_py_q) <<< SHL) + QW'(sk);

  always_ff @(posedge clk_i) begin
    s2_bx_q <= qx[QW-1:32];
    s2_by_q <= qy[QW-1:32];
    s2_sx_q <= qx[31:0];
    s2_sy_q <= qy[31:0];
  end

  // cell hash mod 2^64 from two partial products per axis
  assign s3_hxl_d = $signed(s2_bx_q) * $signed({1'b0, PRX[31:0]});
  assign s3_hyl_d = $signed(s2_by_q) * $signed({1'b0, PRY[31:0]});
  assign s3_hxh_d = 32'($signed(s2_bx_q) * $signed({1'b0, PRX[63:32]}));
  assign s3_hyh_d = 32'($signed(s2_by_q) * $signed({1'b0, PRY[63:32]}));
  assign ssum     = {1'b0, s2_sx_q} + {1'b0, s2_sy_q};
  assign tprod    = $signed({1'b0, ssum}) * UNSKEW_Q32;

  always_ff @(posedge clk_i) begin
    s3_hxl_q <= s3_hxl_d;
    s3_hyl_q <= s3_hyl_d;
    s3_hxh_q <= s3_hxh_d;
    s3_hyh_q <= s3_hyh_d;
    s3_t_q   <= tprod[64:32];
    s3_sx_q  <= s2_sx_q;
    s3_sy_q  <= s2_sy_q;
  end

  assign s4_ux_d = $signed({4'b0, s3_sx_q}) + 36'(s3_t_q);
  assign s4_uy_d = $signed({4'b0, s3_sy_q}) + 36'(s3_t_q);
  assign xa      = $signed({2'b0, s3_sx_q, 1'b0}) - $signed({3'b0, s3_sy_q});
  assign ya      = $signed({2'b0, s3_sy_q, 1'b0}) - $signed({3'b0, s3_sx_q});

  always_ff @(posedge clk_i) begin
    s4_hx_q    <= s3_hxl_q + {s3_hxh_q, 32'b0};
    s4_hy_q    <= s3_hyl_q + {s3_hyh_q, 32'b0};
    s4_ux_q    <= s4_ux_d;
    s4_uy_q    <= s4_uy_d;
    s4_lower_q <= s3_t_q < 33'(UNSKEW_Q32);
    s4_xgt_q   <= xa > ONE_Q32;
    s4_ygt_q   <= ya > ONE_Q32;
    s4_xneg_q  <= xa < 35'sd0;
    s4_yneg_q  <= ya < 35'sd0;
  end

  function automatic corner_t mk_corner(input logic [63:0] hx, input logic [63:0] hy,
                                        input logic signed [35:0] ox,
                                        input logic signed [35:0] oy);
    corner_t c;
    c.key = hx ^ hy;
    c.dx  = 32'(ox >>> 4);
    c.dy  = 32'(oy >>> 4);
    return c;
  endfunction

  logic [63:0] hx1, hx2, hxm, hy1, hy2, hym;

  assign hx1 = s4_hx_q + PRX;
  assign hx2 = s4_hx_q + {PRX[62:0], 1'b0};
  assign hxm = s4_hx_q - PRX;
  assign hy1 = s4_hy_q + PRY;
  assign hy2 = s4_hy_q + {PRY[62:0], 1'b0};
  assign hym = s4_hy_q - PRY;

  always_comb begin
    item_o.crn[0] = mk_corner(s4_hx_q, s4_hy_q, s4_ux_q, s4_uy_q);
    item_o.crn[1] = mk_corner(hx1, hy1, s4_ux_q - OFS_OPP, s4_uy_q - OFS_OPP);
    if (s4_lower_q) begin
      if (s4_xgt_q) begin
        item_o.crn[2] = mk_corner(hx2, hy1, s4_ux_q - OFS_DHI, s4_uy_q - OFS_DLO);
      end else begin
        item_o.crn[2] = mk_corner(s4_hx_q, hy1, s4_ux_q - OFS_UNS, s4_uy_q - OFS_ONE);
      end
      if (s4_ygt_q) begin
        item_o.crn[3] = mk_corner(hx1, hy2, s4_ux_q - OFS_DLO, s4_uy_q - OFS_DHI);
      end else begin
        item_o.crn[3] = mk_corner(hx1, s4_hy_q, s4_ux_q - OFS_ONE, s4_uy_q - OFS_UNS);
      end
    end else begin
      if (s4_xneg_q) begin
        item_o.crn[2] = mk_corner(hxm, s4_hy_q, s4_ux_q + OFS_ONE, s4_uy_q + OFS_UNS);
      end else begin
        item_o.crn[2] = mk_corner(hx1, s4_hy_q, s4_ux_q - OFS_ONE, s4_uy_q - OFS_UNS);
      end
      if (s4_yneg_q) begin
        item_o.crn[3] = mk_corner(s4_hx_q, hym, s4_ux_q + OFS_UNS, s4_uy_q + OFS_ONE);
      end else begin
        item_o.crn[3] = mk_corner(s4_hx_q, hy1, s4_ux_q - OFS_UNS, s4_uy_q - OFS_ONE);
      end
    end
  end

  assign push_o     = vld_q[FRONT_STAGES-1];
  assign inflight_o = 3'($countones(vld_q));

endmodule
`default_nettype wire

@@ design/snz_queue.sv @@
`default_nettype none
module snz_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire snz_pkg::item_t    item_i,
  input  wire logic              pop_i,
  output snz_pkg::item_t         head_o,
  output snz_pkg::queue_status_t status_o
);
  import snz_pkg::*;

  item_t          mem_q [QUEUE_DEPTH];
  logic [QPW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;
  logic           do_push, do_pop;

  assign do_push = push_i && (count_q != QCW'(QUEUE_DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCW'(do_push) - QCW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QCW'(QUEUE_DEPTH));
  assign status_o.count = count_q;

endmodule
`default_nettype wire

@@ design/snz_back.sv @@
`default_nettype none
module snz_back #(
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               pop_i,
  input  wire snz_pkg::item_t     item_i,
  input  wire logic [63:0]        seed_i,
  output logic                    valid_o,
  output logic signed [17:0]      noise_value_o
);
  import snz_pkg::*;

  localparam int unsigned VW  = 66;
  localparam int unsigned RSH = 56 - OUT_FRAC_BITS;
  localparam logic [35:0] TWO_THIRDS_Q28 = 36'd178956971;
  localparam logic signed [VW-1:0] OUT_MAX = VW'(131071);
  localparam logic signed [VW-1:0] OUT_MIN = -(VW'(131072));

  logic [BACK_LATENCY-1:0] vld_q;

  // per-lane stage registers
  logic [63:0]        b1_sqx_q [NUM_CORNERS];
  logic [63:0]        b1_sqy_q [NUM_CORNERS];
  logic [63:0]        b1_hp0_q [NUM_CORNERS];
  logic [31:0]        b1_hp1_q [NUM_CORNERS];
  logic [31:0]        b1_hp2_q [NUM_CORNERS];
  logic signed [31:0] b1_dx_q  [NUM_CORNERS];
  logic signed [31:0] b1_dy_q  [NUM_CORNERS];

  logic [27:0]        b2_att_q [NUM_CORNERS];
  logic               b2_pos_q [NUM_CORNERS];
  grad_t              b2_g_q   [NUM_CORNERS];
  logic signed [31:0] b2_dx_q  [NUM_CORNERS];
  logic signed [31:0] b2_dy_q  [NUM_CORNERS];

  logic [27:0]        b3_a2_q  [NUM_CORNERS];
  logic signed [53:0] b3_pgx_q [NUM_CORNERS];
  logic signed [53:0] b3_pgy_q [NUM_CORNERS];
  logic               b3_pos_q [NUM_CORNERS];

  logic [27:0]        b4_a4_q  [NUM_CORNERS];
  logic signed [38:0] b4_dot_q [NUM_CORNERS];
  logic               b4_pos_q [NUM_CORNERS];

  logic signed [63:0] b5_ctb_q [NUM_CORNERS];

  logic signed [VW-1:0] b6_sum_d, b6_sum_q;
  logic signed [VW-1:0] rnd;
  logic signed [VW-1:0] shr;
  logic signed [17:0]   sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[BACK_LATENCY-2:0], pop_i};
    end
  end

  for (genvar l = 0; l < NUM_CORNERS; l++) begin : g_lane
    logic [63:0]        key;
    logic [63:0]        d2sum;
    logic [35:0]        d2;
    logic [63:0]        h, hm;
    logic [55:0]        att_sq, a2_sq;
    logic signed [54:0] dsum;
    logic signed [63:0] sqx, sqy;
    logic signed [63:0] ctb;

    assign key    = item_i.crn[l].key ^ seed_i;
    assign sqx    = item_i.crn[l].dx * item_i.crn[l].dx;
    assign sqy    = item_i.crn[l].dy * item_i.crn[l].dy;
    assign d2sum  = b1_sqx_q[l] + b1_sqy_q[l];
    assign d2     = d2sum[63:28];
    // gradient hash: seed-mixed key times the scramble constant, mod 2^64
    assign h      = b1_hp0_q[l] + {b1_hp1_q[l] + b1_hp2_q[l], 32'b0};
    assign hm     = h ^ (h >> 58);
    assign att_sq = b2_att_q[l] * b2_att_q[l];
    assign a2_sq  = b3_a2_q[l] * b3_a2_q[l];
    assign dsum   = 55'(b3_pgx_q[l]) + 55'(b3_pgy_q[l]);
    assign ctb    = $signed({1'b0, b4_a4_q[l]}) * b4_dot_q[l];

    always_ff @(posedge clk_i) begin
      b1_sqx_q[l] <= sqx;
      b1_sqy_q[l] <= sqy;
      b1_hp0_q[l] <= key[31:0] * HMUL[31:0];
      b1_hp1_q[l] <= 32'(key[31:0] * HMUL[63:32]);
      b1_hp2_q[l] <= 32'(key[63:32] * HMUL[31:0]);
      b1_dx_q[l]  <= item_i.crn[l].dx;
      b1_dy_q[l]  <= item_i.crn[l].dy;

      b2_pos_q[l] <= d2 < TWO_THIRDS_Q28;
      b2_att_q[l] <= TWO_THIRDS_Q28[27:0] - d2[27:0];
      b2_g_q[l]   <= grad_lookup(mod24(hm[7:1]));
      b2_dx_q[l]  <= b1_dx_q[l];
      b2_dy_q[l]  <= b1_dy_q[l];

      b3_a2_q[l]  <= att_sq[55:28];
      b3_pgx_q[l] <= b2_g_q[l].gx * b2_dx_q[l];
      b3_pgy_q[l] <= b2_g_q[l].gy * b2_dy_q[l];
      b3_pos_q[l] <= b2_pos_q[l];

      b4_a4_q[l]  <= a2_sq[55:28];
      b4_dot_q[l] <= dsum[54:16];
      b4_pos_q[l] <= b3_pos_q[l];

      // corners outside the attenuation radius add nothing
      b5_ctb_q[l] <= b4_pos_q[l] ? ctb : 64'sd0;
    end
  end

  assign b6_sum_d = VW'(b5_ctb_q[0]) + VW'(b5_ctb_q[1]) + VW'(b5_ctb_q[2]) + VW'(b5_ctb_q[3]);

  always_ff @(posedge clk_i) begin
    b6_sum_q <= b6_sum_d;
  end

  // round half up, then clamp to the output range
  assign rnd = b6_sum_q + (VW'(1) <<< (RSH - 1));
  assign shr = rnd >>> RSH;

  always_comb begin
    priority if (shr > OUT_MAX) begin
      sat = 18'sd131071;
    end else if (shr < OUT_MIN) begin
      sat = -18'sd131072;
    end else begin
      sat = shr[17:0];
    end
  end

  always_ff @(posedge clk_i) begin
    noise_value_o <= sat;
  end

  assign valid_o = vld_q[BACK_LATENCY-1];

endmodule
`default_nettype wire

@@ design/simplex_noise_2d.sv @@
`default_nettype none
// 2d gradient noise, one sample per transaction. a sample is taken at every rising edge
// with start high and busy low, so a new position may enter on every clock; the rate
// of one sample per cycle comes from four corner lanes working side by side in the back
// pipeline. each result appears on noise_value_o for exactly one cycle with valid_o high,
// after its sample has passed the 4 front stages, one queue slot and the 7 back stages,
// in the order of the samples; the receiver cannot stall it. busy rises only when the
// queue between front and back would run out of room. write noise_seed_i with
// noise_seed_we_i only while no sample is in flight.
`include "assert_macros.svh"
module simplex_noise_2d #(
  parameter int unsigned COORD_FRAC_BITS = snz_pkg::DEF_COORD_FRAC_BITS,
  parameter int unsigned OUT_FRAC_BITS   = snz_pkg::DEF_OUT_FRAC_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] pos_x_i,
  input  wire logic signed [31:0] pos_y_i,
  input  wire logic               noise_seed_we_i,
  input  wire logic signed [63:0] noise_seed_i,
  output logic                    valid_o,
  output logic signed [17:0]      noise_value_o
);
  import snz_pkg::*;

  logic          accept;
  logic          push, pop;
  logic [2:0]    inflight;
  logic [QCW:0]  occupancy;
  item_t         front_item, head_item;
  queue_status_t q_status;
  logic [63:0]   seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (noise_seed_we_i) begin
      seed_q <= noise_seed_i;
    end
  end

  // items still in the front count against the queue room
  assign occupancy = (QCW+1)'(q_status.count) + (QCW+1)'(inflight);
  assign busy      = occupancy >= (QCW+1)'(QUEUE_DEPTH);
  assign accept    = start && !busy;
  assign pop       = !q_status.empty;

  snz_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .push_o     (push),
    .item_o     (front_item),
    .inflight_o (inflight)
  );

  snz_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .head_o   (head_item),
    .status_o (q_status)
  );

  snz_back #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_i         (pop),
    .item_i        (head_item),
    .seed_i        (seed_q),
    .valid_o       (valid_o),
    .noise_value_o (noise_value_o)
  );

  `ASSERT_NEVER_CLK(a_no_overflow, clk_i, rst_ni, push && q_status.full)
  `ASSERT_CLK(a_front_latency, clk_i, rst_ni, accept |-> ##FRONT_STAGES push)
  `ASSERT_CLK(a_back_latency, clk_i, rst_ni, pop |-> ##BACK_LATENCY valid_o)
  `ASSERT_CLK(a_credit_bound, clk_i, rst_ni, occupancy <= (QCW+1)'(QUEUE_DEPTH))

endmodule
`default_nettype wire

@@ tb/simplex_noise_2d_tb.sv @@
`timescale 1ns / 1ps
module simplex_noise_2d_tb;

  localparam int CLK_HALF = 4;
  localparam int PIPE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_SAMPLES = 620;
  localparam int CALM_TAIL = 150;

  localparam bit [63:0] PRIME_X = 64'h5205402B9270C86F;
  localparam bit [63:0] PRIME_Y = 64'h598CD327003817B5;
  localparam bit [63:0] HASH_MUL = 64'h53A3F72DEEC546F5;
  localparam longint SKEW_Q30 = 393016785;
  localparam longint UNSKEW_Q32 = -907633386;
  localparam longint ONE_Q32 = 64'sh1_0000_0000;
  localparam longint TWO_THIRDS_Q28 = 178956971;
  localparam longint NOISE_MAX = 131071;
  localparam longint NOISE_MIN = -131072;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic noise_seed_we_i = 1'b0;
  logic signed [63:0] noise_seed_i = '0;
  logic valid_o;
  logic signed [17:0] noise_value_o;

  simplex_noise_2d dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .pos_x_i(pos_x_i),
    .pos_y_i(pos_y_i),
    .noise_seed_we_i(noise_seed_we_i),
    .noise_seed_i(noise_seed_i),
    .valid_o(valid_o),
    .noise_value_o(noise_value_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  bit [63:0] seed_model;
  logic signed [17:0] noise_expected[$];
  int err_count = 0;
  int sample_count = 0;
  int checked_count = 0;
  int seed_writes = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  longint grad_x[24] = '{457500, 1104503, 1104503, 457500, -457500, -1104503, -1104503, -457500,
    156045, 727777, 948458, 1185278, 1185278, 948458, 727777, 156045,
    -156045, -727777, -948458, -1185278, -1185278, -948458, -727777, -156045};
  longint grad_y[24] = '{1104503, 457500, -457500, -1104503, -1104503, -457500, 457500, 1104503,
    1185278, 948458, 727777, 156045, -156045, -727777, -948458, -1185278,
    -1185278, -948458, -727777, -156045, 156045, 727777, 948458, 1185278};

  // one lattice corner, 56 fraction bits; offsets come in with 32
  function automatic longint corner_term(bit [63:0] hx, bit [63:0] hy, longint ox, longint oy);
    longint dx, dy, att, a2, a4, dot;
    bit [63:0] h;
    int gi;
    dx = ox >>> 4;
    dy = oy >>> 4;
    att = TWO_THIRDS_Q28 - ((dx * dx + dy * dy) >>> 28);
    if (att <= 0) return 0;
    h = (seed_model ^ hx ^ hy) * HASH_MUL;
    h = h ^ (h >> 58);
    gi = int'(h[7:1]) % 24;
    a2 = (att * att) >>> 28;
    a4 = (a2 * a2) >>> 28;
    dot = (grad_x[gi] * dx + grad_y[gi] * dy) >>> 16;
    return a4 * dot;
  endfunction

  function automatic logic signed [17:0] noise_at(logic signed [31:0] x, logic signed [31:0] y);
    longint px, py, sk, qx, qy, bx, by, sx, sy, t, ux, uy, xa, ya, acc, r;
    longint opp, one_step, dbl_hi, dbl_lo;
    bit [63:0] hx, hy;
    px = longint'(x);
    py = longint'(y);
    sk = ((px + py) * SKEW_Q30) >>> 14;
    qx = px * 65536 + sk;
    qy = py * 65536 + sk;
    bx = qx >>> 32;
    by = qy >>> 32;
    sx = {32'b0, qx[31:0]};
    sy = {32'b0, qy[31:0]};
    hx = bx * PRIME_X;
    hy = by * PRIME_Y;
    t = ((sx + sy) * UNSKEW_Q32) >>> 32;
    ux = sx + t;
    uy = sy + t;
    opp = ONE_Q32 + 2 * UNSKEW_Q32;
    one_step = ONE_Q32 + UNSKEW_Q32;
    dbl_hi = 3 * UNSKEW_Q32 + 2 * ONE_Q32;
    dbl_lo = 3 * UNSKEW_Q32 + ONE_Q32;
    xa = 2 * sx - sy;
    ya = 2 * sy - sx;
    acc = corner_term(hx, hy, ux, uy);
    acc += corner_term(hx + PRIME_X, hy + PRIME_Y, ux - opp, uy - opp);
    if (t < UNSKEW_Q32) begin
      if (xa > ONE_Q32)
        acc += corner_term(hx + (PRIME_X << 1), hy + PRIME_Y, ux - dbl_hi, uy - dbl_lo);
      else
        acc += corner_term(hx, hy + PRIME_Y, ux - UNSKEW_Q32, uy - one_step);
      if (ya > ONE_Q32)
        acc += corner_term(hx + PRIME_X, hy + (PRIME_Y << 1), ux - dbl_lo, uy - dbl_hi);
      else
        acc += corner_term(hx + PRIME_X, hy, ux - one_step, uy - UNSKEW_Q32);
    end else begin
      if (xa < 0)
        acc += corner_term(hx - PRIME_X, hy, ux + one_step, uy + UNSKEW_Q32);
      else
        acc += corner_term(hx + PRIME_X, hy, ux - one_step, uy - UNSKEW_Q32);
      if (ya < 0)
        acc += corner_term(hx, hy - PRIME_Y, ux + UNSKEW_Q32, uy + one_step);
      else
        acc += corner_term(hx, hy + PRIME_Y, ux - UNSKEW_Q32, uy - one_step);
    end
    // round half up to 16 fraction bits, then clamp
    r = (acc + (longint'(1) << 39)) >>> 40;
    if (r > NOISE_MAX) r = NOISE_MAX;
    if (r < NOISE_MIN) r = NOISE_MIN;
    return r[17:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (noise_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d", noise_value_o));
      end else begin
        if (noise_value_o !== noise_expected[0])
          report_mismatch($sformatf("noise_value got %0d want %0d",
                                    noise_value_o, noise_expected[0]));
        void'(noise_expected.pop_front());
        checked_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic pause_start(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // start stays high across back-to-back transactions
  task automatic send_sample(logic signed [31:0] x, logic signed [31:0] y);
    pos_x_i <= x;
    pos_y_i <= y;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    noise_expected.push_back(noise_at(x, y));
    sample_count++;
    if (gaps_on && $urandom_range(0, 3) == 0) pause_start($urandom_range(1, 14));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(bit [63:0] s);
    drain();
    noise_seed_i <= s;
    noise_seed_we_i <= 1'b1;
    @(posedge clk_i);
    noise_seed_we_i <= 1'b0;
    seed_model = s;
    seed_writes++;
  endtask

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      2: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      default: return {$urandom_range(0, 1) ? 8'h7f : 8'h80, 24'($urandom)};
    endcase
  endfunction

  task automatic test_directed();
    send_sample(32'sd0, 32'sd0);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7fff_ffff, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7fff_ffff);
    send_sample(32'hffff_ffff, 32'hffff_ffff);
    send_sample(32'h0001_0000, 32'sd0);
    send_sample(32'sd0, 32'h0001_0000);
    send_sample(32'h0000_8000, 32'h0000_8000);
    send_sample(32'h0000_4000, 32'h0000_c000);
    send_sample(32'h0000_c000, 32'h0000_4000);
    send_sample(32'hffff_8000, 32'h0000_3000);
    send_sample(32'h0003_5555, 32'hfffd_aaab);
    send_sample(32'h0012_3456, 32'h0007_89ab);
    send_sample(32'h5555_5555, 32'haaaa_aaaa);
    send_sample(32'haaaa_aaaa, 32'h5555_5555);
  endtask

  // extremes of the seed plus a few random ones
  task automatic test_seed_sweep();
    bit [63:0] seeds[6];
    seeds = '{64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
              {$urandom, $urandom}, {$urandom, $urandom}, 64'h0};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      repeat (20) send_sample(pick_coord(), pick_coord());
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      if (i == RANDOM_SAMPLES - CALM_TAIL) gaps_on = 1'b0;
      if (i % 200 == 199) write_seed({$urandom, $urandom});
      send_sample(pick_coord(), pick_coord());
    end
  endtask

  initial begin
    seed_model = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_seed_sweep();
    test_random();
    drain();
    $display("%0d samples sent, %0d results checked", sample_count, checked_count);
    $display("%0d seed writes incl. extremes; random gaps then back-to-back", seed_writes);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ simplex_noise_2d.f @@
+incdir+design
design/snz_pkg.sv
design/snz_front.sv
design/snz_queue.sv
design/snz_back.sv
design/simplex_noise_2d.sv
tb/simplex_noise_2d_tb.sv
